// ===== design/nec_ir_pulse_decoder_unit_defines.svh =====
// Assertion macros for the NEC IR pulse decoder.
// No dependencies; included by the top level only.
`ifndef NEC_IR_PULSE_DECODER_UNIT_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nir assertion failed");

// Next-cycle implication, disabled during reset.
`define NIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nir assertion failed");

`endif

// ===== design/nir_pkg.sv =====
// Types, codes and constants of the NEC IR pulse decoder.
// No dependencies.
package nir_pkg;

  localparam int MODE_W     = 2;
  localparam int WIDTH_W    = 16;
  localparam int KEY_W      = 8;
  localparam int COUNT_W    = 8;
  localparam int TICKS_W    = 4;
  localparam int WORD_W     = 32;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;

  localparam logic [MODE_W-1:0] MODE_RISE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FALL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCAN = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd7;

  localparam logic [WIDTH_W-1:0] RST_ZERO_MIN   = 16'd300;
  localparam logic [WIDTH_W-1:0] RST_ZERO_MAX   = 16'd800;
  localparam logic [WIDTH_W-1:0] RST_ONE_MIN    = 16'd1400;
  localparam logic [WIDTH_W-1:0] RST_ONE_MAX    = 16'd1800;
  localparam logic [WIDTH_W-1:0] RST_REPEAT_MIN = 16'd2200;
  localparam logic [WIDTH_W-1:0] RST_REPEAT_MAX = 16'd2600;
  localparam logic [WIDTH_W-1:0] RST_LEADER_MIN = 16'd4200;
  localparam logic [WIDTH_W-1:0] RST_LEADER_MAX = 16'd4700;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [WIDTH_W-1:0] zero_min;
    logic [WIDTH_W-1:0] zero_max;
    logic [WIDTH_W-1:0] one_min;
    logic [WIDTH_W-1:0] one_max;
    logic [WIDTH_W-1:0] repeat_min;
    logic [WIDTH_W-1:0] repeat_max;
    logic [WIDTH_W-1:0] leader_min;
    logic [WIDTH_W-1:0] leader_max;
  } nir_windows_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_code;
    logic [COUNT_W-1:0] press_count;
    logic               leader_active;
    logic               frame_complete;
  } nir_result_t;

  typedef struct packed {
    logic               leader;
    logic [TICKS_W-1:0] ticks;
    logic [COUNT_W-1:0] count;
  } nir_status_t;

  // Exclusive bounds on both sides.
  function automatic logic in_window(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] lo,
                                     logic [WIDTH_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

endpackage

// ===== design/nir_channels.sv =====
// Valid/ready channel interfaces of the NEC IR pulse decoder.
// No dependencies.
interface nir_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] pulse_width;

  modport source (output valid, output mode, output pulse_width, input ready);
  modport sink   (input valid, input mode, input pulse_width, output ready);
endinterface

interface nir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic [7:0] press_count;
  logic       leader_active;
  logic       frame_complete;

  modport source (output valid, output key_code, output press_count,
                  output leader_active, output frame_complete, input ready);
  modport sink   (input valid, input key_code, input press_count,
                  input leader_active, input frame_complete, output ready);
endinterface

// ===== design/nir_cfg_regs.sv =====
// Width window registers of the NEC IR pulse decoder.
// Depends on nir_pkg.
module nir_cfg_regs
  import nir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_wdata,
  output nir_windows_t         windows
);

  nir_windows_t win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.zero_min   <= RST_ZERO_MIN;
      win_r.zero_max   <= RST_ZERO_MAX;
      win_r.one_min    <= RST_ONE_MIN;
      win_r.one_max    <= RST_ONE_MAX;
      win_r.repeat_min <= RST_REPEAT_MIN;
      win_r.repeat_max <= RST_REPEAT_MAX;
      win_r.leader_min <= RST_LEADER_MIN;
      win_r.leader_max <= RST_LEADER_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_MIN:   win_r.zero_min   <= cfg_wdata;
        REG_ZERO_MAX:   win_r.zero_max   <= cfg_wdata;
        REG_ONE_MIN:    win_r.one_min    <= cfg_wdata;
        REG_ONE_MAX:    win_r.one_max    <= cfg_wdata;
        REG_REPEAT_MIN: win_r.repeat_min <= cfg_wdata;
        REG_REPEAT_MAX: win_r.repeat_max <= cfg_wdata;
        REG_LEADER_MIN: win_r.leader_min <= cfg_wdata;
        REG_LEADER_MAX: win_r.leader_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign windows = win_r;

endmodule

// ===== design/nir_decode.sv =====
// Decoder state and per-event update of the NEC IR pulse decoder.
// Depends on nir_pkg.
module nir_decode
  import nir_pkg::*;
#(
  parameter int REMOTE_ADDRESS = 0,
  parameter int TIMEOUT_TICKS  = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [MODE_W-1:0]  mode,
  input  logic [WIDTH_W-1:0] pulse_width,
  input  nir_windows_t       windows,
  output nir_result_t        result,
  output nir_status_t        status
);

  localparam logic [KEY_W-1:0]   ADDR_ID     = KEY_W'(REMOTE_ADDRESS);
  localparam logic [TICKS_W-1:0] TIMEOUT_LIM = TICKS_W'(TIMEOUT_TICKS);

  logic [WORD_W-1:0]  shift_r, shift_nxt;
  logic               leader_r, leader_nxt;
  logic               complete_r, complete_nxt;
  logic               rise_r, rise_nxt;
  logic [TICKS_W-1:0] ticks_r, ticks_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0]   key;

  logic [KEY_W-1:0] addr_b, naddr_b, cmd_b, ncmd_b, scan_key;
  logic             in_zero, in_one, in_rep, in_lead;

  assign addr_b  = shift_r[7:0];
  assign naddr_b = shift_r[15:8];
  assign cmd_b   = shift_r[23:16];
  assign ncmd_b  = shift_r[31:24];
  assign scan_key = ((addr_b == ~naddr_b) && (addr_b == ADDR_ID) && (cmd_b == ~ncmd_b))
                    ? cmd_b : '0;

  assign in_zero = in_window(pulse_width, windows.zero_min, windows.zero_max);
  assign in_one  = in_window(pulse_width, windows.one_min, windows.one_max);
  assign in_rep  = in_window(pulse_width, windows.repeat_min, windows.repeat_max);
  assign in_lead = in_window(pulse_width, windows.leader_min, windows.leader_max);

  always_comb begin
    shift_nxt    = shift_r;
    leader_nxt   = leader_r;
    complete_nxt = complete_r;
    rise_nxt     = rise_r;
    ticks_nxt    = ticks_r;
    count_nxt    = count_r;
    key          = '0;
    case (mode)
      MODE_RISE: begin
        rise_nxt = 1'b1;
      end
      MODE_FALL: begin
        if (rise_r) begin
          if (leader_r) begin
            if (in_zero) begin
              shift_nxt = {1'b0, shift_r[WORD_W-1:1]};
            end else if (in_one) begin
              shift_nxt = {1'b1, shift_r[WORD_W-1:1]};
            end else if (in_rep) begin
              if (count_r != COUNT_MAX) begin
                count_nxt = count_r + 1'b1;
              end
              ticks_nxt = '0;
            end
          end else if (in_lead) begin
            leader_nxt = 1'b1;
            count_nxt  = '0;
          end
        end
        rise_nxt = 1'b0;
      end
      MODE_TICK: begin
        if (leader_r) begin
          rise_nxt = 1'b0;
          if (ticks_r == '0) begin
            complete_nxt = 1'b1;
          end
          if (ticks_r < TIMEOUT_LIM) begin
            ticks_nxt = ticks_r + 1'b1;
          end else begin
            leader_nxt = 1'b0;
            ticks_nxt  = '0;
          end
        end
      end
      MODE_SCAN: begin
        if (complete_r) begin
          key = scan_key;
          if ((scan_key == '0) || !leader_r) begin
            complete_nxt = 1'b0;
            count_nxt    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      leader_r   <= 1'b0;
      complete_r <= 1'b0;
      rise_r     <= 1'b0;
      ticks_r    <= '0;
      count_r    <= '0;
    end else if (step_en) begin
      shift_r    <= shift_nxt;
      leader_r   <= leader_nxt;
      complete_r <= complete_nxt;
      rise_r     <= rise_nxt;
      ticks_r    <= ticks_nxt;
      count_r    <= count_nxt;
    end
  end

  assign result.key_code       = key;
  assign result.press_count    = count_nxt;
  assign result.leader_active  = leader_nxt;
  assign result.frame_complete = complete_nxt;

  assign status.leader = leader_r;
  assign status.ticks  = ticks_r;
  assign status.count  = count_r;

endmodule

// ===== design/nec_ir_pulse_decoder_unit.sv =====
// NEC IR pulse decoder, top level: input register, decoder, result register.
// Depends on nir_pkg, nir_channels, nir_cfg_regs, nir_decode and the defines header.
// Path: the input register takes a transaction, then the result register holds its result.
// Throughput: one transaction per cycle; a full input and a full result register
// stall only while the result side holds ready low.
// Reset (synchronous, rst_n low): decoder state cleared, windows back to defaults.
`include "nec_ir_pulse_decoder_unit_defines.svh"
module nec_ir_pulse_decoder_unit
  import nir_pkg::*;
#(
  parameter int REMOTE_ADDRESS = 0,
  parameter int TIMEOUT_TICKS  = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nir_in_if.sink               in_ch,
  nir_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_wdata
);

  nir_windows_t windows;
  nir_result_t  result;
  nir_status_t  status;

  logic               s1_valid_r;
  logic [MODE_W-1:0]  s1_mode_r;
  logic [WIDTH_W-1:0] s1_width_r;
  logic               out_valid_r;
  nir_result_t        out_r;

  logic s2_free, advance, in_take;
  logic chk_plain, chk_idle_tick, chk_sat;

  assign s2_free = !out_valid_r || out_ch.ready;
  assign advance = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign in_take = in_ch.valid && in_ch.ready;

  nir_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .windows   (windows)
  );

  nir_decode #(
    .REMOTE_ADDRESS (REMOTE_ADDRESS),
    .TIMEOUT_TICKS  (TIMEOUT_TICKS)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .mode        (s1_mode_r),
    .pulse_width (s1_width_r),
    .windows     (windows),
    .result      (result),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_ch.mode;
      s1_width_r <= in_ch.pulse_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.key_code       = out_r.key_code;
  assign out_ch.press_count    = out_r.press_count;
  assign out_ch.leader_active  = out_r.leader_active;
  assign out_ch.frame_complete = out_r.frame_complete;

  assign chk_plain     = advance && (s1_mode_r != MODE_SCAN);
  assign chk_idle_tick = advance && (s1_mode_r == MODE_TICK) && !status.leader;
  assign chk_sat       = advance && (status.count == COUNT_MAX) && (s1_mode_r != MODE_SCAN) &&
                         ((s1_mode_r != MODE_FALL) || status.leader);

  // key only on a scan transaction
  `NIR_ASSERT_NXT(a_key_scan_only, clk, rst_n, chk_plain, out_ch.key_code == '0)
  // tick without a leader leaves the timeout counter alone
  `NIR_ASSERT_NXT(a_idle_tick, clk, rst_n, chk_idle_tick, status.ticks == $past(status.ticks))
  // a saturated count holds outside a scan
  `NIR_ASSERT_NXT(a_count_sat, clk, rst_n, chk_sat, status.count == COUNT_MAX)

endmodule
